FILE: rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation pipeline.
// No dependencies.
package bsc_pkg;

   localparam int NumRegs = 5;
   localparam int CsrIndexWidth = 3;
   localparam int DivStages = 32;

   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [15:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_tenths;
      logic signed [31:0] pressure_pa;
      logic               divide_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
   } coef_type;

   // Low 32 bits of a product.
   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

FILE: rtl/core/bsc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bsc_pkg. Side data rides along with each beat.
module bsc_div #(
   parameter int SideWidth = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          in_num,
   input  logic [31:0]          in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [31:0]          out_quo,
   output logic [SideWidth-1:0] out_side
);
   localparam int N = bsc_pkg::DivStages;

   // Stage s registers hold the state after step s.
   logic [N-1:0]         vld_ff;
   logic [31:0]          rem_ff   [N-1];
   logic [31:0]          den_ff   [N-1];
   logic [31:0]          quo_ff   [N];
   logic [SideWidth-1:0] side_ff  [N];

   // Operands seen by each step.
   logic [31:0]          rem_cur  [N];
   logic [31:0]          quo_cur  [N];
   logic [31:0]          den_cur  [N];
   logic [SideWidth-1:0] side_cur [N];
   logic [32:0]          shifted  [N];
   logic [32:0]          trial    [N];

   // Feed step 0 from the ports, every later step from the stage before it.
   always_comb begin
      rem_cur[0]  = 32'd0;
      quo_cur[0]  = in_num;
      den_cur[0]  = in_den;
      side_cur[0] = in_side;
      for (int s = 1; s < N; s++) begin
         rem_cur[s]  = rem_ff[s-1];
         quo_cur[s]  = quo_ff[s-1];
         den_cur[s]  = den_ff[s-1];
         side_cur[s] = side_ff[s-1];
      end
      for (int s = 0; s < N; s++) begin
         shifted[s] = {rem_cur[s], quo_cur[s][31]};
         trial[s]   = shifted[s] - {1'b0, den_cur[s]};
      end
   end

   // One shift-subtract step per stage; valid bits advance with the data.
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[N-2:0], in_valid};
      for (int s = 0; s < N; s++) begin
         side_ff[s] <= side_cur[s];
         quo_ff[s]  <= {quo_cur[s][30:0], !trial[s][32]};
      end
      for (int s = 0; s < N - 1; s++) begin
         den_ff[s] <= den_cur[s];
         rem_ff[s] <= trial[s][32] ? shifted[s][31:0] : trial[s][31:0];
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule

FILE: rtl/core/bsc_temp.sv
// Temperature half: X1, X2 = (MC<<11)/(X1+MD), B5 and T.
// Depends on bsc_pkg and bsc_div.
module bsc_temp (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bsc_pkg::req_type  in_req,
   input  bsc_pkg::coef_type coef,
   output logic              out_valid,
   output logic [31:0]       out_t,
   output logic [31:0]       out_b5,
   output logic [15:0]       out_up,
   output logic              out_err
);
   logic        s1_vld_ff;
   logic [31:0] s1_x1_ff, s1_den_ff, s1_num_ff;
   logic [15:0] s1_up_ff;
   logic        s1_neg_ff;
   logic [31:0] x1_in, den_in, num_in;

   // Stage 1: X1 and the signed division operands.
   assign x1_in = bsc_pkg::asr32(bsc_pkg::mul32({16'd0, in_req.raw_temperature}
                   - {16'd0, coef.ac5_ac6[15:0]}, {16'd0, coef.ac5_ac6[31:16]}), 15);
   assign den_in = x1_in + bsc_pkg::sx16(coef.mc_md[15:0]);
   assign num_in = bsc_pkg::sx16(coef.mc_md[31:16]) << 11;

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else s1_vld_ff <= in_valid;
      s1_x1_ff  <= x1_in;
      s1_den_ff <= den_in[31] ? -den_in : den_in;
      s1_num_ff <= num_in[31] ? -num_in : num_in;
      s1_neg_ff <= num_in[31] ^ den_in[31];
      s1_up_ff  <= in_req.raw_pressure;
   end

   localparam int SideW = 32 + 16 + 1 + 1;
   logic             dv_vld;
   logic [31:0]      dv_quo;
   logic [SideW-1:0] dv_side;

   bsc_div #(.SideWidth(SideW)) u_div (
      .clock(clock), .reset(reset), .in_valid(s1_vld_ff),
      .in_num(s1_num_ff), .in_den(s1_den_ff),
      .in_side({s1_x1_ff, s1_up_ff, s1_neg_ff, (s1_den_ff == 32'd0)}),
      .out_valid(dv_vld), .out_quo(dv_quo), .out_side(dv_side)
   );

   logic [31:0] x2, b5;
   assign x2 = dv_side[1] ? -dv_quo : dv_quo;
   assign b5 = dv_side[SideW-1 -: 32] + x2;

   // Stage out: B5 and T.
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else out_valid <= dv_vld;
      out_b5  <= b5;
      out_t   <= bsc_pkg::asr32(b5 + 32'd8, 4);
      out_up  <= dv_side[17:2];
      out_err <= dv_side[0];
   end
endmodule

FILE: rtl/core/bsc_press.sv
// Pressure half: B6..B7, unsigned division and the final correction.
// Depends on bsc_pkg and bsc_div.
module bsc_press (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [31:0]       in_t,
   input  logic [31:0]       in_b5,
   input  logic [15:0]       in_up,
   input  logic              in_err,
   input  bsc_pkg::coef_type coef,
   output logic              out_valid,
   output bsc_pkg::rsp_type  out_rsp
);
   // Stage A: B6 and its square.
   logic        a_vld_ff, a_err_ff;
   logic [31:0] a_b6_ff, a_sq_ff, a_t_ff;
   logic [15:0] a_up_ff;
   logic [31:0] b6;
   assign b6 = in_b5 - 32'd4000;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else a_vld_ff <= in_valid;
      a_b6_ff <= b6;
      a_sq_ff <= bsc_pkg::asr32(bsc_pkg::mul32(b6, b6), 12);
      a_t_ff <= in_t; a_up_ff <= in_up; a_err_ff <= in_err;
   end

   // Stage B: the four coefficient products.
   logic        b_vld_ff, b_err_ff;
   logic [31:0] b_p1_ff, b_p2_ff, b_p3_ff, b_p4_ff, b_t_ff;
   logic [15:0] b_up_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else b_vld_ff <= a_vld_ff;
      b_p1_ff <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef.b1_b2[15:0]), a_sq_ff), 11);
      b_p2_ff <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef.ac1_ac2[15:0]), a_b6_ff), 11);
      b_p3_ff <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef.ac3_ac4[31:16]), a_b6_ff), 13);
      b_p4_ff <= bsc_pkg::asr32(bsc_pkg::mul32(bsc_pkg::sx16(coef.b1_b2[31:16]), a_sq_ff), 16);
      b_t_ff <= a_t_ff; b_up_ff <= a_up_ff; b_err_ff <= a_err_ff;
   end

   // Stage C: B3 (truncating /4) and X3.
   logic        c_vld_ff, c_err_ff;
   logic [31:0] c_b3_ff, c_x3_ff, c_t_ff;
   logic [15:0] c_up_ff;
   logic [31:0] b3_sum, x3_in;
   assign b3_sum = (bsc_pkg::sx16(coef.ac1_ac2[31:16]) << 2) + b_p1_ff + b_p2_ff + 32'd2;
   assign x3_in = bsc_pkg::asr32(b_p3_ff + b_p4_ff + 32'd2, 2);
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else c_vld_ff <= b_vld_ff;
      c_b3_ff <= bsc_pkg::asr32(b3_sum + (b3_sum[31] ? 32'd3 : 32'd0), 2);
      c_x3_ff <= x3_in + 32'd32768;
      c_t_ff <= b_t_ff; c_up_ff <= b_up_ff; c_err_ff <= b_err_ff;
   end

   // Stage D: B4 and B7.
   logic        d_vld_ff, d_err_ff;
   logic [31:0] d_b4_ff, d_b7_ff, d_t_ff;
   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else d_vld_ff <= c_vld_ff;
      d_b4_ff <= bsc_pkg::mul32({16'd0, coef.ac3_ac4[15:0]}, c_x3_ff) >> 15;
      d_b7_ff <= bsc_pkg::mul32({16'd0, c_up_ff} - c_b3_ff, 32'd50000);
      d_t_ff <= c_t_ff; d_err_ff <= c_err_ff;
   end

   localparam int SideW = 32 + 1 + 1;
   logic             dv_vld;
   logic [31:0]      dv_quo;
   logic [SideW-1:0] dv_side;
   bsc_div #(.SideWidth(SideW)) u_div (
      .clock(clock), .reset(reset), .in_valid(d_vld_ff),
      .in_num(d_b7_ff[31] ? d_b7_ff : {d_b7_ff[30:0], 1'b0}), .in_den(d_b4_ff),
      .in_side({d_t_ff, d_b7_ff[31], d_err_ff || (d_b4_ff == 32'd0)}),
      .out_valid(dv_vld), .out_quo(dv_quo), .out_side(dv_side)
   );

   // Stage E: P and the correction products.
   logic        e_vld_ff, e_err_ff;
   logic [31:0] e_p_ff, e_x1_ff, e_x2_ff, e_t_ff;
   logic [31:0] p, ps;
   assign p = dv_side[1] ? {dv_quo[30:0], 1'b0} : dv_quo;
   assign ps = bsc_pkg::asr32(p, 8);
   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else e_vld_ff <= dv_vld;
      e_p_ff  <= p;
      e_x1_ff <= bsc_pkg::mul32(ps, ps);
      e_x2_ff <= bsc_pkg::asr32(bsc_pkg::mul32(32'hFFFF_E343, p), 16);
      e_t_ff <= dv_side[SideW-1 -: 32]; e_err_ff <= dv_side[0];
   end

   // Stage F: scale X1.
   logic        f_vld_ff, f_err_ff;
   logic [31:0] f_p_ff, f_x1_ff, f_x2_ff, f_t_ff;
   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else f_vld_ff <= e_vld_ff;
      f_x1_ff <= bsc_pkg::asr32(bsc_pkg::mul32(e_x1_ff, 32'd3038), 16);
      f_p_ff <= e_p_ff; f_x2_ff <= e_x2_ff; f_t_ff <= e_t_ff; f_err_ff <= e_err_ff;
   end

   // Output register.
   logic [31:0] pf;
   assign pf = f_p_ff + bsc_pkg::asr32(f_x1_ff + f_x2_ff + 32'd3791, 4);
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else out_valid <= f_vld_ff;
      out_rsp.temperature_tenths <= f_err_ff ? 32'sd0 : $signed(f_t_ff);
      out_rsp.pressure_pa        <= f_err_ff ? 32'sd0 : $signed(pf);
      out_rsp.divide_error       <= f_err_ff;
   end
endmodule

FILE: rtl/core/barometric_sensor_compensation_unit.sv
// Barometric compensation unit: a fully pipelined path from start to rsp_valid.
// Throughput: one beat per cycle; busy is always low, the two 32-stage dividers set depth.
// The receiver cannot stall; each result shows for one cycle on rsp_valid.
// Synchronous reset clears pipeline valid bits and coefficient registers to zero.
// Depends on bsc_pkg, bsc_temp, bsc_press, bsc_div.
module barometric_sensor_compensation_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  bsc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output bsc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bsc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [31:0]                           csr_data
);
   bsc_pkg::coef_type coef_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // Decode register writes; indices past the list drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bsc_pkg::REG_AC1_AC2: coef_ff.ac1_ac2 <= csr_data;
            bsc_pkg::REG_AC3_AC4: coef_ff.ac3_ac4 <= csr_data;
            bsc_pkg::REG_AC5_AC6: coef_ff.ac5_ac6 <= csr_data;
            bsc_pkg::REG_B1_B2:   coef_ff.b1_b2   <= csr_data;
            bsc_pkg::REG_MC_MD:   coef_ff.mc_md   <= csr_data;
            default: ;
         endcase
      end
   end

   logic        t_vld, t_err;
   logic [31:0] t_t, t_b5;
   logic [15:0] t_up;

   bsc_temp u_temp (
      .clock(clock), .reset(reset), .in_valid(start && !busy), .in_req(req_data),
      .coef(coef_ff), .out_valid(t_vld), .out_t(t_t), .out_b5(t_b5),
      .out_up(t_up), .out_err(t_err)
   );

   bsc_press u_press (
      .clock(clock), .reset(reset), .in_valid(t_vld), .in_t(t_t), .in_b5(t_b5),
      .in_up(t_up), .in_err(t_err), .coef(coef_ff),
      .out_valid(rsp_valid), .out_rsp(rsp_data)
   );

   // An error result always carries zero outputs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_error |->
         rsp_data.pressure_pa == 0 && rsp_data.temperature_tenths == 0)
      else $error("error beat with nonzero data");

   // No result comes out the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   // Temperature stage valid follows an accepted beat by its latency.
   assert property (@(posedge clock) disable iff (reset)
      t_vld |-> $past(start, 34))
      else $error("temperature stage valid without start");
endmodule
